// File: rtl/sprite_animation_sequencer_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sprite animation sequencer
// Concurrent assertion wrappers that compile away in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef SPRITE_ANIMATION_SEQUENCER_UNIT_DEFINES_SVH
`define SPRITE_ANIMATION_SEQUENCER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define SAS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("sas assertion failed");
// Antecedent in one cycle implies consequent in the next.
`define SAS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sas assertion failed");
`else
`define SAS_ASSERT(lbl, clk, rst_n, prop)
`define SAS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/sas_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sas_pkg
// Types and constants shared by the sprite animation sequencer modules.
// ----------------------------------------------------------------------------
package sas_pkg;

  // Frame numbers at or above this count take the wrap or hold rule.
  localparam int unsigned MAX_FRAMES = 256;

  // Bits of a frame number, and so the steps of the restoring divider.
  localparam int unsigned FRAME_W   = 8;
  localparam int unsigned DIV_STEPS = FRAME_W;

  // Item commands.
  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_LOAD = 1'b1;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_FRAME_WIDTH    = 3'd0,
    CFG_FRAME_HEIGHT   = 3'd1,
    CFG_SHEET_COLUMNS  = 3'd2,
    CFG_FIRST_FRAME    = 3'd3,
    CFG_LAST_FRAME     = 3'd4,
    CFG_FRAME_DELAY_US = 3'd5,
    CFG_LOOP_ENABLE    = 3'd6
  } cfg_idx_e;

  // Reset values of the configuration registers.
  localparam logic [12:0] RST_FRAME_WIDTH    = 13'd2;
  localparam logic [12:0] RST_FRAME_HEIGHT   = 13'd2;
  localparam logic [8:0]  RST_SHEET_COLUMNS  = 9'd1;
  localparam logic [7:0]  RST_FIRST_FRAME    = 8'd0;
  localparam logic [7:0]  RST_LAST_FRAME     = 8'd0;
  localparam logic [19:0] RST_FRAME_DELAY_US = 20'd1000000;
  localparam logic        RST_LOOP_ENABLE    = 1'b1;

  typedef struct packed {
    logic [2:0]  index;
    logic [19:0] value;
  } cfg_word_t;

  typedef struct packed {
    logic        func;
    logic [19:0] elapsed_us;
    logic [7:0]  new_frame;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  frame_index;
    logic [19:0] rect_left;
    logic [19:0] rect_top;
    logic [20:0] rect_right;
    logic [20:0] rect_bottom;
    logic        anim_done;
  } out_word_t;

  typedef struct packed {
    logic [12:0] frame_width;
    logic [12:0] frame_height;
    logic [8:0]  sheet_columns;
    logic [7:0]  first_frame;
    logic [7:0]  last_frame;
    logic [19:0] frame_delay_us;
    logic        loop_enable;
  } cfg_t;

  // Divider command and status.
  typedef struct packed {
    logic         start;
    logic [7:0]   dividend;
    logic [8:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic         done;
    logic [7:0]   quotient;
    logic [8:0]   remainder;
  } div_rsp_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_ACCUM,
    S_STEP,
    S_DIV_START,
    S_DIV,
    S_MUL_LEFT,
    S_MUL_TOP,
    S_OUT
  } seq_state_e;

endpackage

// File: rtl/sas_chan_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sas_chan_if
// Valid/ready channel carrying one word of a given payload type.
// ----------------------------------------------------------------------------
interface sas_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/sas_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sas_cfg_regs
// Configuration register file written through the configuration channel.
// ----------------------------------------------------------------------------
module sas_cfg_regs import sas_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  sas_chan_if.sink    cfg_i,
  output cfg_t        cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.data.index)
        CFG_FRAME_WIDTH:    cfg_d.frame_width    = cfg_i.data.value[12:0];
        CFG_FRAME_HEIGHT:   cfg_d.frame_height   = cfg_i.data.value[12:0];
        CFG_SHEET_COLUMNS:  cfg_d.sheet_columns  = cfg_i.data.value[8:0];
        CFG_FIRST_FRAME:    cfg_d.first_frame    = cfg_i.data.value[7:0];
        CFG_LAST_FRAME:     cfg_d.last_frame     = cfg_i.data.value[7:0];
        CFG_FRAME_DELAY_US: cfg_d.frame_delay_us = cfg_i.data.value;
        CFG_LOOP_ENABLE:    cfg_d.loop_enable    = cfg_i.data.value[0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width    <= RST_FRAME_WIDTH;
      cfg_q.frame_height   <= RST_FRAME_HEIGHT;
      cfg_q.sheet_columns  <= RST_SHEET_COLUMNS;
      cfg_q.first_frame    <= RST_FIRST_FRAME;
      cfg_q.last_frame     <= RST_LAST_FRAME;
      cfg_q.frame_delay_us <= RST_FRAME_DELAY_US;
      cfg_q.loop_enable    <= RST_LOOP_ENABLE;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// File: rtl/sas_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sas_divider
// Restoring divider, one quotient bit per cycle through a shared subtractor.
// ----------------------------------------------------------------------------
`include "sprite_animation_sequencer_unit_defines.svh"

module sas_divider import sas_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int unsigned CntW = $clog2(DIV_STEPS);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [8:0]      rem_q, rem_d;
  logic [7:0]      quo_q, quo_d;
  logic [8:0]      divisor_q, divisor_d;

  logic [8:0]      trial;
  logic [9:0]      diff;

  // The partial remainder stays below the divisor (at most 255), so the
  // shifted trial value fits in nine bits.
  assign trial = {rem_q[7:0], quo_q[7]};
  assign diff  = {1'b0, trial} - {1'b0, divisor_q};

  always_comb begin
    busy_d    = busy_q;
    done_d    = 1'b0;
    cnt_d     = cnt_q;
    rem_d     = rem_q;
    quo_d     = quo_q;
    divisor_d = divisor_q;
    if (req_i.start) begin
      busy_d    = 1'b1;
      cnt_d     = '0;
      rem_d     = '0;
      quo_d     = req_i.dividend;
      divisor_d = req_i.divisor;
    end else if (busy_q) begin
      if (!diff[9]) begin
        rem_d = diff[8:0];
        quo_d = {quo_q[6:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[6:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(DIV_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q     <= rem_d;
    quo_q     <= quo_d;
    divisor_q <= divisor_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

  `SAS_ASSERT(a_done_after_busy, clk_i, rst_ni, done_q |-> $past(busy_q))
  `SAS_ASSERT(a_rem_below_divisor, clk_i, rst_ni, done_q |-> (rem_q < divisor_q))
  `SAS_ASSERT(a_start_when_free, clk_i, rst_ni, req_i.start |-> !busy_q)

endmodule

// File: rtl/sprite_animation_sequencer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_animation_sequencer_unit
// Sprite-sheet frame animation sequencer with cell rectangle lookup.
// ----------------------------------------------------------------------------
// Each input word is either a time tick (func 0) carrying elapsed microseconds
// or a load command (func 1) that sets the current frame and clears the done
// flag. A tick acts only when last_frame is above first_frame: it adds its
// time to a 32-bit timer that saturates at all ones, and once the timer
// exceeds frame_delay_us the delay is taken off once and the frame advances
// by one. A frame that leaves the first..last window (or reaches the frame
// count) wraps to first_frame when loop_enable is set, and otherwise holds at
// last_frame and raises anim_done. Every input word produces exactly one
// result word with the frame and its cell rectangle: column and row are the
// frame modulo and divided by sheet_columns (zero columns act as one), and
// left/top are column*frame_width and row*frame_height. Each word runs
// through the eight-step restoring divider that splits the frame into row
// and column, then through two passes of one shared 8x13 multiplier; an
// active tick first passes the timer add and frame step states. A new word
// is accepted only once the block is back in its idle state. The result
// sits in an output register, so the next word is accepted while a result
// still waits to be taken; the block stalls only if a second result is
// ready before the first has left. Configuration is always accepted and
// must be written only while the block is idle.
// ----------------------------------------------------------------------------
`include "sprite_animation_sequencer_unit_defines.svh"

module sprite_animation_sequencer_unit import sas_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  sas_chan_if.sink   cfg_i,
  sas_chan_if.sink   item_i,
  sas_chan_if.source result_o
);

  cfg_t       cfg;
  div_req_t   div_req;
  div_rsp_t   div_rsp;

  seq_state_e state_q, state_d;

  // Architectural state: timer, current frame and done flag.
  logic [31:0] accum_q, accum_d;
  logic [7:0]  frame_q, frame_d;
  logic        done_q, done_d;

  // Item and datapath holding registers.
  logic [19:0] elapsed_q, elapsed_d;
  logic [20:0] left_q, left_d;
  logic [20:0] top_q, top_d;
  out_word_t   out_q, out_d;
  logic        out_valid_q, out_valid_d;

  logic        item_accept;
  logic [32:0] accum_sum;
  logic [8:0]  next_frame;
  logic        wrap_frame;
  logic [8:0]  cols;
  logic [7:0]  mul_a;
  logic [12:0] mul_b;
  logic [20:0] mul_p;

  sas_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  sas_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign item_i.ready    = (state_q == S_IDLE);
  assign item_accept     = item_i.valid && item_i.ready;
  assign result_o.valid  = out_valid_q;
  assign result_o.data   = out_q;

  // Saturating timer add; the carry out means the sum passed all ones.
  assign accum_sum = {1'b0, accum_q} + 33'(elapsed_q);

  // Candidate frame after an advance, kept one bit wider to see 256.
  assign next_frame = {1'b0, frame_q} + 9'd1;
  assign wrap_frame = (32'(next_frame) >= MAX_FRAMES)
                   || (next_frame < {1'b0, cfg.first_frame})
                   || (next_frame > {1'b0, cfg.last_frame});

  assign cols = (cfg.sheet_columns == '0) ? 9'd1 : cfg.sheet_columns;

  // One multiplier serves both axes: column by width, then row by height.
  // The remainder is at most the frame number, so its low byte is exact.
  assign mul_a = (state_q == S_MUL_LEFT) ? div_rsp.remainder[7:0] : div_rsp.quotient;
  assign mul_b = (state_q == S_MUL_LEFT) ? cfg.frame_width : cfg.frame_height;
  assign mul_p = 21'(mul_a) * 21'(mul_b);

  always_comb begin
    state_d          = state_q;
    accum_d          = accum_q;
    frame_d          = frame_q;
    done_d           = done_q;
    elapsed_d        = elapsed_q;
    left_d           = left_q;
    top_d            = top_q;
    out_d            = out_q;
    out_valid_d      = out_valid_q;
    div_req.start    = 1'b0;
    div_req.dividend = frame_q;
    div_req.divisor  = cols;

    if (result_o.valid && result_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (item_accept) begin
          elapsed_d = item_i.data.elapsed_us;
          if (item_i.data.func == FUNC_LOAD) begin
            frame_d = item_i.data.new_frame;
            done_d  = 1'b0;
            state_d = S_DIV_START;
          end else if (cfg.last_frame > cfg.first_frame) begin
            state_d = S_ACCUM;
          end else begin
            // Inactive window: the tick leaves all state alone.
            state_d = S_DIV_START;
          end
        end
      end
      S_ACCUM: begin
        accum_d = accum_sum[32] ? '1 : accum_sum[31:0];
        state_d = S_STEP;
      end
      S_STEP: begin
        if (accum_q > 32'(cfg.frame_delay_us)) begin
          accum_d = accum_q - 32'(cfg.frame_delay_us);
          if (!wrap_frame) begin
            frame_d = next_frame[7:0];
          end else if (cfg.loop_enable) begin
            frame_d = cfg.first_frame;
          end else begin
            frame_d = cfg.last_frame;
            done_d  = 1'b1;
          end
        end
        state_d = S_DIV_START;
      end
      S_DIV_START: begin
        div_req.start = 1'b1;
        state_d       = S_DIV;
      end
      S_DIV: begin
        if (div_rsp.done) begin
          state_d = S_MUL_LEFT;
        end
      end
      S_MUL_LEFT: begin
        left_d  = mul_p;
        state_d = S_MUL_TOP;
      end
      S_MUL_TOP: begin
        top_d   = mul_p;
        state_d = S_OUT;
      end
      S_OUT: begin
        // Load the output register once it is empty or being emptied.
        if (!out_valid_q || result_o.ready) begin
          out_d.frame_index = frame_q;
          out_d.rect_left   = left_q[19:0];
          out_d.rect_top    = top_q[19:0];
          out_d.rect_right  = left_q + 21'(cfg.frame_width);
          out_d.rect_bottom = top_q + 21'(cfg.frame_height);
          out_d.anim_done   = done_q;
          out_valid_d       = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      accum_q     <= '0;
      frame_q     <= '0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      accum_q     <= accum_d;
      frame_q     <= frame_d;
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    elapsed_q <= elapsed_d;
    left_q    <= left_d;
    top_q     <= top_d;
    out_q     <= out_d;
  end

  `SAS_ASSERT(a_div_done_in_wait, clk_i, rst_ni, div_rsp.done |-> (state_q == S_DIV))
  `SAS_ASSERT_NEXT(a_accum_no_wrap, clk_i, rst_ni, state_q == S_ACCUM, accum_q >= $past(accum_q))
  `SAS_ASSERT(a_step_after_accum, clk_i, rst_ni, (state_q == S_STEP) |-> ($past(state_q) == S_ACCUM))

endmodule
